// ===== hw/rtl/sha256_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 byte stream hash unit.
package sha256_pkg;

    // Block geometry and padding positions
    localparam logic [5:0] LAST_POS   = 6'd63;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [7:0] MARK_BYTE  = 8'h80;
    localparam logic [7:0] ZERO_BYTE  = 8'h00;
    localparam logic [1:0] LAST_INDEX = 2'd3;

    // Round constants
    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Initial hash value
    localparam logic [31:0] HASH_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_UPDATE,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        SRC_INPUT,
        SRC_MARK,
        SRC_ZERO,
        SRC_LEN
    } byte_src_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic      shift_in;
        logic      count_msg;
        byte_src_t src;
        logic      round_en;
        logic [5:0] round_idx;
        logic      update_hash;
        logic      finish;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [5:0] pos;
        logic       out_busy;
    } dp_stat_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                           input logic [31:0] g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

// ===== hw/rtl/sha256_byte_stream_hash_unit.sv =====
// SHA-256 byte stream hash unit: the top level joining controller and datapath.
// Takes a message one byte per beat and returns its SHA-256 digest as four 64-bit beats,
// most significant first, then starts over for the next message. A beat with tuser low
// carries no byte; tlast ends the message (an empty message is a lone tlast beat with
// tuser low). Every 64th byte starts a compression (64 rounds on one shared round unit,
// then a fold into the hash) during which tready is low. At the end of a message the unit
// pads one byte per cycle up to the next block boundary (with one more compression when
// the length no longer fits in the current block), compresses, and loads the digest into
// an output register; the input reopens the cycle after that, while the four digest beats
// drain. A following message end waits until the previous digest has been fully taken.
module sha256_byte_stream_hash_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] byte_present
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] digest_word
    output logic [1:0]  m_axis_tuser,   // [1:0] word_index
    output logic        m_axis_tlast    // last_word
);
    import sha256_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    sha256_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_present (s_axis_tuser),
        .in_end     (s_axis_tlast),
        .in_ready   (s_axis_tready),
        .cmd        (cmd),
        .stat       (stat)
    );

    sha256_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_byte   (s_axis_tdata),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_word  (m_axis_tdata),
        .out_index (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule

// ===== hw/rtl/sha256_dp.sv =====
// Datapath: block shift register and message schedule, round logic, hash state, digest output.
module sha256_dp
(
    input  logic                clk,
    input  logic                rst_n,
    input  sha256_pkg::dp_cmd_t cmd,
    output sha256_pkg::dp_stat_t stat,
    input  logic [7:0]          in_byte,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [63:0]         out_word,
    output logic [1:0]          out_index,
    output logic                out_last
);
    import sha256_pkg::*;

    logic [31:0]  hash_reg [8];
    logic [31:0]  hash_next [8];
    logic [31:0]  vars_reg [8];
    logic [31:0]  vars_next [8];
    logic [511:0] blk_reg;
    logic [511:0] blk_next;
    logic [60:0]  cnt_reg;
    logic [60:0]  cnt_next;
    logic [5:0]   pos_reg;
    logic [5:0]   pos_next;
    logic [255:0] out_reg;
    logic [255:0] out_next;
    logic         oval_reg;
    logic         oval_next;
    logic [1:0]   oidx_reg;
    logic [1:0]   oidx_next;

    logic [63:0]  bit_len;
    logic [63:0]  len_shift;
    logic [7:0]   push_byte;
    logic [31:0]  w0;
    logic [31:0]  w1;
    logic [31:0]  w9;
    logic [31:0]  w14;
    logic [31:0]  w_new;
    logic [31:0]  t1;
    logic [31:0]  t2;

    // Select the byte to shift in: message, pad mark, zero or length
    always_comb
    begin
        bit_len   = {cnt_reg, 3'b000};
        len_shift = bit_len << {pos_reg[2:0], 3'b000};
        case (cmd.src)
            SRC_INPUT: push_byte = in_byte;
            SRC_MARK:  push_byte = MARK_BYTE;
            SRC_ZERO:  push_byte = ZERO_BYTE;
            SRC_LEN:   push_byte = len_shift[63:56];
            default:   push_byte = ZERO_BYTE;
        endcase
    end

    // Schedule window taps: word j of the window is W[t+j]
    always_comb
    begin
        w0    = blk_reg[511:480];
        w1    = blk_reg[479:448];
        w9    = blk_reg[223:192];
        w14   = blk_reg[63:32];
        w_new = ssig1(w14) + w9 + ssig0(w1) + w0;
        t1    = vars_reg[7] + bsig1(vars_reg[4]) + choose(vars_reg[4], vars_reg[5], vars_reg[6])
              + ROUND_K[cmd.round_idx] + w0;
        t2    = bsig0(vars_reg[0]) + majority(vars_reg[0], vars_reg[1], vars_reg[2]);
    end

    // Next state of block, schedule, working variables and hash
    always_comb
    begin
        blk_next = blk_reg;
        cnt_next = cnt_reg;
        pos_next = pos_reg;
        for (int i = 0; i < 8; i++)
        begin
            hash_next[i] = hash_reg[i];
            vars_next[i] = vars_reg[i];
        end

        if (cmd.shift_in)
        begin
            blk_next = {blk_reg[503:0], push_byte};
            pos_next = pos_reg + 6'd1;
        end
        if (cmd.count_msg)
        begin
            cnt_next = cnt_reg + 61'd1;
        end

        // One compression round; the window advances one word
        if (cmd.round_en)
        begin
            blk_next     = {blk_reg[479:0], w_new};
            vars_next[7] = vars_reg[6];
            vars_next[6] = vars_reg[5];
            vars_next[5] = vars_reg[4];
            vars_next[4] = vars_reg[3] + t1;
            vars_next[3] = vars_reg[2];
            vars_next[2] = vars_reg[1];
            vars_next[1] = vars_reg[0];
            vars_next[0] = t1 + t2;
        end

        // Fold the block result into the hash; keep the working copy equal
        if (cmd.update_hash)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_next[i] = hash_reg[i] + vars_reg[i];
                vars_next[i] = hash_reg[i] + vars_reg[i];
            end
        end

        // Start over for the next message
        if (cmd.finish)
        begin
            cnt_next = '0;
            pos_next = '0;
            for (int i = 0; i < 8; i++)
            begin
                hash_next[i] = HASH_IV[i];
                vars_next[i] = HASH_IV[i];
            end
        end
    end

    // Digest output register: load four words, drain one per beat
    always_comb
    begin
        out_next  = out_reg;
        oval_next = oval_reg;
        oidx_next = oidx_reg;
        if (cmd.finish)
        begin
            for (int i = 0; i < 8; i++)
            begin
                out_next[255 - 32 * i -: 32] = hash_reg[i];
            end
            oval_next = 1'b1;
            oidx_next = '0;
        end
        else if (oval_reg && out_ready)
        begin
            out_next  = {out_reg[191:0], 64'd0};
            oidx_next = oidx_reg + 2'd1;
            oval_next = (oidx_reg != LAST_INDEX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= HASH_IV[i];
                vars_reg[i] <= HASH_IV[i];
            end
            cnt_reg  <= '0;
            pos_reg  <= '0;
            oval_reg <= 1'b0;
            oidx_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= hash_next[i];
                vars_reg[i] <= vars_next[i];
            end
            cnt_reg  <= cnt_next;
            pos_reg  <= pos_next;
            oval_reg <= oval_next;
            oidx_reg <= oidx_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        out_reg <= out_next;
    end

    assign stat.pos      = pos_reg;
    assign stat.out_busy = oval_reg;
    assign out_valid     = oval_reg;
    assign out_word      = out_reg[255:192];
    assign out_index     = oidx_reg;
    assign out_last      = (oidx_reg == LAST_INDEX);

endmodule

// ===== hw/rtl/sha256_ctrl.sv =====
// Controller: state machine sequencing byte intake, padding, rounds and digest hand-off.
module sha256_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_present,
    input  logic                 in_end,
    output logic                 in_ready,
    output sha256_pkg::dp_cmd_t  cmd,
    input  sha256_pkg::dp_stat_t stat
);
    import sha256_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    logic [5:0] round_reg;
    logic [5:0] round_next;
    logic       pad_reg;
    logic       pad_next;
    logic       mark_reg;
    logic       mark_next;
    logic       len_reg;
    logic       len_next;
    logic       len_now;
    logic       block_full;

    // Length bytes start at position 56 once the mark is in
    assign len_now    = !mark_reg && (len_reg || (stat.pos == LEN_POS));
    assign block_full = (stat.pos == LAST_POS);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_present && block_full)
                    begin
                        state_next = S_ROUND;
                    end
                    else if (in_end)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                if (block_full)
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                if (round_reg == LAST_ROUND)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                if (len_reg)
                begin
                    state_next = S_DONE;
                end
                else if (pad_reg)
                begin
                    state_next = S_PAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb
    begin
        in_ready        = 1'b0;
        cmd.shift_in    = 1'b0;
        cmd.count_msg   = 1'b0;
        cmd.src         = SRC_INPUT;
        cmd.round_en    = 1'b0;
        cmd.round_idx   = round_reg;
        cmd.update_hash = 1'b0;
        cmd.finish      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.shift_in  = in_valid && in_present;
                cmd.count_msg = in_valid && in_present;
            end
            S_PAD:
            begin
                cmd.shift_in = 1'b1;
                if (mark_reg)
                begin
                    cmd.src = SRC_MARK;
                end
                else if (len_now)
                begin
                    cmd.src = SRC_LEN;
                end
                else
                begin
                    cmd.src = SRC_ZERO;
                end
            end
            S_ROUND:
            begin
                cmd.round_en = 1'b1;
            end
            S_UPDATE:
            begin
                cmd.update_hash = 1'b1;
            end
            S_DONE:
            begin
                cmd.finish = !stat.out_busy;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Round counter and padding flags
    always_comb
    begin
        round_next = round_reg;
        pad_next   = pad_reg;
        mark_next  = mark_reg;
        len_next   = len_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_end)
                begin
                    pad_next  = 1'b1;
                    mark_next = 1'b1;
                    len_next  = 1'b0;
                end
            end
            S_PAD:
            begin
                if (mark_reg)
                begin
                    mark_next = 1'b0;
                end
                else if (len_now)
                begin
                    len_next = 1'b1;
                end
            end
            S_ROUND:
            begin
                round_next = round_reg + 6'd1;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    pad_next = 1'b0;
                    len_next = 1'b0;
                end
            end
            default:
            begin
                round_next = round_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            round_reg <= '0;
            pad_reg   <= 1'b0;
            mark_reg  <= 1'b0;
            len_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            pad_reg   <= pad_next;
            mark_reg  <= mark_next;
            len_reg   <= len_next;
        end
    end

endmodule
